// ----- rtl/wsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and codes shared by the frame deframer core and its step logic.
// ----------------------------------------------------------------------------
package wsfd_pkg;

   // parser phases, one-hot
   typedef enum logic [4:0] {
      PH_HDR1    = 5'b00001,
      PH_HDR2    = 5'b00010,
      PH_EXTLEN  = 5'b00100,
      PH_MASK    = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_last;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic [3:0] frame_opcode;
      logic       frame_end;
      logic       aborted;
   } rsp_type;

   // parser state apart from the frame length counter
   typedef struct packed {
      phase_type   phase;
      logic [3:0]  cur_opcode;
      logic        mask_on;
      logic [3:0]  bytes_left;
      logic [31:0] mask_key;
      logic [1:0]  payload_index;
   } state_type;

endpackage

// ----- rtl/wsfd_step.sv -----
// ----------------------------------------------------------------------------
// wsfd_step
// Next-state and result logic for one received byte of the frame parser.
// ----------------------------------------------------------------------------
module wsfd_step #(
   parameter int LENGTH_BITS = 64
) (
   input  wsfd_pkg::state_type     cur_state,
   input  logic [LENGTH_BITS-1:0]  cur_rem,
   input  wsfd_pkg::req_type       req,
   output wsfd_pkg::state_type     nxt_state,
   output logic [LENGTH_BITS-1:0]  nxt_rem,
   output logic                    emit,
   output wsfd_pkg::rsp_type       rsp
);

   logic [7:0]             key_byte;
   logic [LENGTH_BITS-1:0] rem_dec;
   logic [LENGTH_BITS-1:0] rem_shift;
   logic                   valid;
   logic                   frame_done;
   logic                   abort_f;
   logic [7:0]             pbyte;

   assign rem_dec   = cur_rem - LENGTH_BITS'(1);
   assign rem_shift = {cur_rem[LENGTH_BITS-9:0], req.rx_byte};

   always_comb begin
      case (cur_state.payload_index)
         2'd0:    key_byte = cur_state.mask_key[31:24];
         2'd1:    key_byte = cur_state.mask_key[23:16];
         2'd2:    key_byte = cur_state.mask_key[15:8];
         default: key_byte = cur_state.mask_key[7:0];
      endcase
   end

   always_comb begin
      nxt_state  = cur_state;
      nxt_rem    = cur_rem;
      valid      = 1'b0;
      frame_done = 1'b0;
      abort_f    = 1'b0;
      pbyte      = 8'd0;

      case (cur_state.phase)
         wsfd_pkg::PH_HDR2: begin
            nxt_state.mask_on  = req.rx_byte[7];
            nxt_state.mask_key = 32'd0;
            nxt_rem            = '0;
            if (req.rx_byte[6:0] == wsfd_pkg::LEN7_EXT16) begin
               nxt_state.bytes_left = wsfd_pkg::EXT16_BYTES;
               nxt_state.phase      = wsfd_pkg::PH_EXTLEN;
            end else if (req.rx_byte[6:0] == wsfd_pkg::LEN7_EXT64) begin
               nxt_state.bytes_left = wsfd_pkg::EXT64_BYTES;
               nxt_state.phase      = wsfd_pkg::PH_EXTLEN;
            end else begin
               nxt_rem = LENGTH_BITS'(req.rx_byte[6:0]);
               if (req.rx_byte[7]) begin
                  nxt_state.bytes_left = wsfd_pkg::KEY_BYTES;
                  nxt_state.phase      = wsfd_pkg::PH_MASK;
               end else begin
                  nxt_state.payload_index = 2'd0;
                  if (req.rx_byte[6:0] == 7'd0) begin
                     nxt_state.phase = wsfd_pkg::PH_HDR1;
                     frame_done      = 1'b1;
                  end else begin
                     nxt_state.phase = wsfd_pkg::PH_PAYLOAD;
                  end
               end
            end
         end
         wsfd_pkg::PH_EXTLEN: begin
            // saturate when another byte would overflow the counter
            if (cur_rem[LENGTH_BITS-1 -: 8] != 8'd0) begin
               nxt_rem = '1;
            end else begin
               nxt_rem = rem_shift;
            end
            nxt_state.bytes_left = cur_state.bytes_left - 4'd1;
            if (cur_state.bytes_left == 4'd1) begin
               if (cur_state.mask_on) begin
                  nxt_state.bytes_left = wsfd_pkg::KEY_BYTES;
                  nxt_state.phase      = wsfd_pkg::PH_MASK;
               end else begin
                  nxt_state.payload_index = 2'd0;
                  if (nxt_rem == '0) begin
                     nxt_state.phase = wsfd_pkg::PH_HDR1;
                     frame_done      = 1'b1;
                  end else begin
                     nxt_state.phase = wsfd_pkg::PH_PAYLOAD;
                  end
               end
            end
         end
         wsfd_pkg::PH_MASK: begin
            nxt_state.mask_key   = {cur_state.mask_key[23:0], req.rx_byte};
            nxt_state.bytes_left = cur_state.bytes_left - 4'd1;
            if (cur_state.bytes_left == 4'd1) begin
               nxt_state.payload_index = 2'd0;
               if (cur_rem == '0) begin
                  nxt_state.phase = wsfd_pkg::PH_HDR1;
                  frame_done      = 1'b1;
               end else begin
                  nxt_state.phase = wsfd_pkg::PH_PAYLOAD;
               end
            end
         end
         wsfd_pkg::PH_PAYLOAD: begin
            pbyte                   = req.rx_byte ^ (cur_state.mask_on ? key_byte : 8'd0);
            valid                   = 1'b1;
            nxt_state.payload_index = cur_state.payload_index + 2'd1;
            nxt_rem                 = rem_dec;
            if (rem_dec == '0) begin
               frame_done      = 1'b1;
               nxt_state.phase = wsfd_pkg::PH_HDR1;
            end
         end
         default: begin
            nxt_state.cur_opcode = req.rx_byte[3:0];
            nxt_state.phase      = wsfd_pkg::PH_HDR2;
         end
      endcase

      // buffer end with a frame still open drops it
      if (req.buffer_last && nxt_state.phase != wsfd_pkg::PH_HDR1) begin
         abort_f                 = 1'b1;
         frame_done              = 1'b1;
         nxt_state.phase         = wsfd_pkg::PH_HDR1;
         nxt_state.bytes_left    = 4'd0;
         nxt_state.payload_index = 2'd0;
      end
   end

   assign emit             = valid | frame_done;
   assign rsp.payload_byte = pbyte;
   assign rsp.byte_valid   = valid;
   assign rsp.frame_opcode = nxt_state.cur_opcode;
   assign rsp.frame_end    = frame_done;
   assign rsp.aborted      = abort_f;

endmodule

// ----- rtl/websocket_frame_deframer_core.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Receive-side WebSocket frame parser: header, length, mask key, payload.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per transaction, with buffer_last set on
//   the final byte of a receive buffer. rsp_* carries at most one result per
//   byte: an unmasked payload byte, a zero-length frame end marker, or an
//   abort marker when a buffer ends inside a frame.
//   Each result is registered and appears on rsp_valid the cycle after its
//   byte is taken. Throughput: one byte per cycle while the receiver does
//   not stall; the parser state and the frame length counter (LENGTH_BITS
//   wide, one decrement and zero test) are updated once per byte.
//   Header and mask key bytes give no result unless the frame completes or
//   aborts on them.
//   A single output register holds the result; while the receiver stalls
//   with a result pending, req_ready drops and no byte is taken. A byte that
//   gives no result is still taken as soon as the register is free.
//   Reset (synchronous, active high) returns the parser to the first header
//   byte, clears the length, key and opcode, and empties the output register.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core #(
   parameter int LENGTH_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  wsfd_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output wsfd_pkg::rsp_type  rsp_data
);

   wsfd_pkg::state_type    state_ff;
   wsfd_pkg::state_type    state_in;
   logic [LENGTH_BITS-1:0] rem_ff;
   logic [LENGTH_BITS-1:0] rem_in;
   logic                   rsp_valid_ff;
   wsfd_pkg::rsp_type      rsp_data_ff;
   wsfd_pkg::rsp_type      rsp_data_in;
   logic                   emit;
   logic                   accept;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   wsfd_step #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_step (
      .cur_state(state_ff),
      .cur_rem  (rem_ff),
      .req      (req_data),
      .nxt_state(state_in),
      .nxt_rem  (rem_in),
      .emit     (emit),
      .rsp      (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= wsfd_pkg::PH_HDR1;
         state_ff.cur_opcode    <= 4'd0;
         state_ff.mask_on       <= 1'b0;
         state_ff.bytes_left    <= 4'd0;
         state_ff.mask_key      <= 32'd0;
         state_ff.payload_index <= 2'd0;
         rem_ff                 <= '0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (accept) begin
            state_ff     <= state_in;
            rem_ff       <= rem_in;
            rsp_valid_ff <= emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an abort always closes the frame
   a_abort_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.aborted || rsp_data_ff.frame_end))
      else $error("aborted result without frame_end");

   // buffer end always leaves the parser waiting for a new header
   a_buffer_end_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.buffer_last) |=> (state_ff.phase == wsfd_pkg::PH_HDR1))
      else $error("parser not at first header byte after buffer end");

   // only payload bytes produce a data result
   a_data_from_payload: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.phase != wsfd_pkg::PH_PAYLOAD)
      |=> !(rsp_valid_ff && rsp_data_ff.byte_valid))
      else $error("data result from a header byte");

   // unmasked zero-length header gives an end marker right away
   a_zero_length_marker: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.phase == wsfd_pkg::PH_HDR2 && req_data.rx_byte[7:0] == 8'd0)
      |=> (rsp_valid_ff && rsp_data_ff.frame_end && !rsp_data_ff.byte_valid))
      else $error("zero-length frame gave no end marker");

endmodule
